FILE: hw/rtl/bbem_pkg.sv
// Package for the blockwise binary entropy map: sizes, result kinds, stage
// structs and the entropy lookup table built at elaboration.
// No dependencies; every other file of the block uses it.
package bbem_pkg;

  localparam int unsigned GRID_CELLS = 16;
  localparam int unsigned SIDE       = 3 * GRID_CELLS;
  localparam int unsigned POS_W      = $clog2(SIDE);
  localparam int unsigned BAND_W     = $clog2(GRID_CELLS);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned SUM_FULL   = 2295;
  localparam int unsigned ENT_FRAC   = 16;
  localparam int unsigned ENT_W      = 16;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned MEAN_SHIFT = 2 * BAND_W;
  localparam int unsigned COORD_W    = 4;

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int unsigned FIFO_MARK  = FIFO_DEPTH / 2;

  typedef enum logic {
    KIND_CELL = 1'b0,
    KIND_MEAN = 1'b1
  } kind_e;

  typedef struct packed {
    logic               done;
    logic               last;
    logic               clr;
    logic [BAND_W-1:0]  row;
    logic [BAND_W-1:0]  col;
    logic [SUM_W-1:0]   sum;
  } cell_req_t;

  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic [ENT_W-1:0]   entropy;
    logic               last;
  } result_t;

  typedef logic [SUM_FULL:0][ENT_W-1:0] ent_rom_t;

  // Shift and subtract quotient, used only while the table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Natural logs come from a series of 2*atanh(1/(2k-1)) terms in Q60,
  // rounded to Q48; the entropy of every window sum is then tabulated.
  function automatic ent_rom_t build_ent_rom();
    logic [63:0] ln_q [0:SUM_FULL];
    logic [63:0] acc;
    logic [63:0] d;
    logic [63:0] d2;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] c;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] num;
    logic [63:0] h48;
    logic [63:0] rnd;
    ent_rom_t    rom;
    acc = '0;
    ln_q[0] = '0;
    ln_q[1] = '0;
    for (int unsigned k = 2; k <= SUM_FULL; k++) begin
      d   = 64'(2 * k - 1);
      d2  = d * d;
      t   = div_u64(64'd1 << 61, d);
      sum = '0;
      n   = '0;
      while (t != 64'd0) begin
        sum = sum + div_u64(t, 2 * n + 64'd1);
        t   = div_u64(t, d2);
        n   = n + 64'd1;
      end
      acc     = acc + sum;
      ln_q[k] = (acc + (64'd1 << 11)) >> 12;
    end
    c = 64'(SUM_FULL) * ln_q[SUM_FULL];
    for (int unsigned s = 0; s <= SUM_FULL; s++) begin
      a   = 64'(s) * ln_q[s];
      b   = 64'(SUM_FULL - s) * ln_q[SUM_FULL - s];
      num = (c >= a + b) ? c - a - b : 64'd0;
      h48 = div_u64(num, 64'(SUM_FULL));
      rnd = (h48 + (64'd1 << (47 - ENT_FRAC))) >> (48 - ENT_FRAC);
      rom[s] = rnd[ENT_W-1:0];
    end
    return rom;
  endfunction

  localparam ent_rom_t ENT_ROM = build_ent_rom();

endpackage

FILE: hw/rtl/blockwise_binary_entropy_map_top.sv
// Top level of the blockwise binary entropy map: window stage, entropy ROM,
// frame total and mean, and the output queue.
// Depends on bbem_pkg, bbem_window, bbem_ent_rom and bbem_out_fifo.
//
// The input channel carries one 8-bit pixel per transfer of a 48x48 image in
// raster order; tuser marks the first pixel of a frame and clears all sums.
// The output channel carries one result per transfer: a cell entropy for each
// of the 16x16 cells as its last pixel arrives, then the frame mean with
// tlast set, right after the cell from the final pixel.
// A pixel is taken in every cycle while s_axis_tready is high. The table lookup
// is one registered ROM read. A cell result is queued behind the window request
// register and the ROM read; the mean is queued in the cycle after the final cell.
// Results pass through a 16-entry queue. When the receiver stalls, the queue
// fills and s_axis_tready drops once more than eight results wait, which
// leaves room for everything already in the pipeline.
// Reset clears the position counters, band sums, frame total and queue; the
// first pixel after reset is taken as pixel (0,0).
module blockwise_binary_entropy_map_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] cell_row, [7:4] cell_col, [23:8] entropy
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast    // last
);

  bbem_pkg::cell_req_t                req;
  logic                               accept, room;
  logic [bbem_pkg::ENT_W-1:0]         ent;
  logic                               b_cell_q, b_last_q, b_clr_q;
  logic [bbem_pkg::BAND_W-1:0]        b_row_q, b_col_q;
  logic [bbem_pkg::TOTAL_W-1:0]       total_q, total_d, total_new;
  logic                               mean_vld_q;
  logic [bbem_pkg::ENT_W-1:0]         mean_q;
  logic                               push;
  bbem_pkg::result_t                  push_data, head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  bbem_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .req_o         (req)
  );

  bbem_ent_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (req.sum),
    .data_o (ent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_cell_q   <= 1'b0;
      b_last_q   <= 1'b0;
      b_clr_q    <= 1'b0;
      total_q    <= '0;
      mean_vld_q <= 1'b0;
    end else begin
      b_cell_q   <= req.done;
      b_last_q   <= req.last;
      b_clr_q    <= req.clr;
      total_q    <= total_d;
      mean_vld_q <= b_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_row_q <= req.row;
    b_col_q <= req.col;
    mean_q  <= total_new[bbem_pkg::MEAN_SHIFT +: bbem_pkg::ENT_W];
  end

  always_comb begin
    total_new = (b_clr_q ? '0 : total_q)
              + (b_cell_q ? bbem_pkg::TOTAL_W'(ent) : '0);
    total_d   = b_last_q ? '0 : total_new;

    push = b_cell_q || mean_vld_q;
    if (b_cell_q) begin
      push_data.kind     = bbem_pkg::KIND_CELL;
      push_data.cell_row = bbem_pkg::COORD_W'(b_row_q);
      push_data.cell_col = bbem_pkg::COORD_W'(b_col_q);
      push_data.entropy  = ent;
      push_data.last     = 1'b0;
    end else begin
      push_data.kind     = bbem_pkg::KIND_MEAN;
      push_data.cell_row = '0;
      push_data.cell_col = '0;
      push_data.entropy  = mean_q;
      push_data.last     = 1'b1;
    end
  end

  bbem_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (head),
    .room_o      (room)
  );

  assign m_axis_tdata = {head.entropy, head.cell_col, head.cell_row};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

FILE: hw/rtl/bbem_window.sv
// Window stage: raster position counters, per-band 3x3 partial sums with
// mirrored edges, and the registered cell request for each pixel.
// Depends on bbem_pkg.
module bbem_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [bbem_pkg::PIX_W-1:0]    pixel_i,
  input  logic                          frame_start_i,
  output bbem_pkg::cell_req_t           req_o
);

  localparam logic [bbem_pkg::POS_W-1:0]  PosLast = bbem_pkg::POS_W'(bbem_pkg::SIDE - 1);
  localparam logic [bbem_pkg::POS_W-1:0]  PosTwin = bbem_pkg::POS_W'(bbem_pkg::SIDE - 2);
  localparam logic [bbem_pkg::POS_W-1:0]  PosSide = bbem_pkg::POS_W'(bbem_pkg::SIDE);
  localparam logic [bbem_pkg::BAND_W-1:0] BandLast =
    bbem_pkg::BAND_W'(bbem_pkg::GRID_CELLS - 1);
  localparam logic [bbem_pkg::SUM_W-1:0]  SumFull = bbem_pkg::SUM_W'(bbem_pkg::SUM_FULL);

  logic [bbem_pkg::POS_W-1:0]  row_q, row_d, col_q, col_d, r_e, c_e;
  logic [1:0]                  rph_q, rph_d, cph_q, cph_d, rph_e, cph_e;
  logic [bbem_pkg::BAND_W-1:0] rb_q, rb_d, cb_q, cb_d, rb_e, cb_e;
  logic [bbem_pkg::SUM_W-1:0]  band_q [bbem_pkg::GRID_CELLS];
  logic [bbem_pkg::SUM_W-1:0]  cur, add, sum_new, sat;
  logic [1:0]                  sh;
  logic                        clr, acc_en, row_end, col_end, cell_done, last;
  bbem_pkg::cell_req_t         req_q, req_d;

  always_comb begin
    clr   = frame_start_i || (row_q >= PosSide) || (col_q >= PosSide);
    r_e   = clr ? '0 : row_q;
    c_e   = clr ? '0 : col_q;
    rph_e = clr ? '0 : rph_q;
    cph_e = clr ? '0 : cph_q;
    rb_e  = clr ? '0 : rb_q;
    cb_e  = clr ? '0 : cb_q;

    cur     = clr ? '0 : band_q[cb_e];
    sh      = {1'b0, r_e == PosTwin} + {1'b0, c_e == PosTwin};
    add     = bbem_pkg::SUM_W'(pixel_i) << sh;
    sum_new = cur + add;
    sat     = (sum_new > SumFull) ? SumFull : sum_new;

    acc_en    = (r_e != '0) && (c_e != '0);
    row_end   = (r_e != '0) && ((rph_e == 2'd0) || (r_e == PosLast));
    col_end   = (c_e != '0) && ((cph_e == 2'd0) || (c_e == PosLast));
    cell_done = acc_en && row_end && col_end;
    last      = (r_e == PosLast) && (c_e == PosLast);

    row_d = r_e;
    rph_d = rph_e;
    rb_d  = rb_e;
    col_d = c_e + 1'b1;
    cph_d = (cph_e == 2'd2) ? 2'd0 : cph_e + 2'd1;
    cb_d  = ((cph_e == 2'd0) && (c_e != '0) && (cb_e != BandLast)) ? cb_e + 1'b1 : cb_e;
    if (last) begin
      row_d = '0;
      rph_d = '0;
      rb_d  = '0;
      col_d = '0;
      cph_d = '0;
      cb_d  = '0;
    end else if (c_e == PosLast) begin
      col_d = '0;
      cph_d = '0;
      cb_d  = '0;
      row_d = r_e + 1'b1;
      rph_d = (rph_e == 2'd2) ? 2'd0 : rph_e + 2'd1;
      rb_d  = ((rph_e == 2'd0) && (r_e != '0) && (rb_e != BandLast)) ? rb_e + 1'b1 : rb_e;
    end

    req_d.done = accept_i && cell_done;
    req_d.last = accept_i && last;
    req_d.clr  = accept_i && clr;
    req_d.row  = rb_e;
    req_d.col  = cb_e;
    req_d.sum  = sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      rph_q <= '0;
      cph_q <= '0;
      rb_q  <= '0;
      cb_q  <= '0;
      for (int i = 0; i < bbem_pkg::GRID_CELLS; i++) begin
        band_q[i] <= '0;
      end
    end else if (accept_i) begin
      row_q <= row_d;
      col_q <= col_d;
      rph_q <= rph_d;
      cph_q <= cph_d;
      rb_q  <= rb_d;
      cb_q  <= cb_d;
      for (int i = 0; i < bbem_pkg::GRID_CELLS; i++) begin
        if (clr || last) begin
          band_q[i] <= '0;
        end else if (acc_en && (cb_e == bbem_pkg::BAND_W'(i))) begin
          band_q[i] <= cell_done ? '0 : sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

FILE: hw/rtl/bbem_ent_rom.sv
// Entropy lookup ROM with a registered read port.
// Depends on bbem_pkg for the table contents.
module bbem_ent_rom (
  input  logic                        clk_i,
  input  logic [bbem_pkg::SUM_W-1:0]  addr_i,
  output logic [bbem_pkg::ENT_W-1:0]  data_o
);

  logic [bbem_pkg::ENT_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= bbem_pkg::ENT_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

FILE: hw/rtl/bbem_out_fifo.sv
// Result queue between the entropy pipeline and the output channel.
// Depends on bbem_pkg for the result struct and the queue sizes.
module bbem_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bbem_pkg::result_t    push_data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output bbem_pkg::result_t    data_o,
  output logic                 room_o
);

  bbem_pkg::result_t                mem_q [bbem_pkg::FIFO_DEPTH];
  logic [bbem_pkg::FIFO_PTR_W-1:0]  wr_q, rd_q;
  logic [bbem_pkg::FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                             do_pop;

  always_comb begin
    do_pop = pop_i && (cnt_q != '0);
    cnt_d  = cnt_q + bbem_pkg::FIFO_CNT_W'(push_i) - bbem_pkg::FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= bbem_pkg::FIFO_CNT_W'(bbem_pkg::FIFO_MARK));

endmodule
